// File: design/brb_pkg.sv
// Shared types and constants of the chunked circular byte FIFO.
package brb_pkg;

    localparam int DATA_W  = 64;
    localparam int LEN_W   = 4;
    localparam int FILL_W  = 13;
    localparam int LANE_W  = 3;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] read_bytes;
        logic [LEN_W-1:0]  moved;
        logic [FILL_W-1:0] fill_level;
    } result_t;

endpackage

// File: design/brb_ram.sv
// Byte-wide ring store: one write port, one read port, registered read data.
module brb_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/brb_seq.sv
// Request sequencer: pointers, fill count and the byte-by-byte store loop.
module brb_seq #(
    parameter int DEPTH       = 4096,
    parameter int CHUNK_BYTES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [brb_pkg::OP_W-1:0]       req_op,
    input  logic [brb_pkg::DATA_W-1:0]     req_data,
    input  logic [brb_pkg::LEN_W-1:0]      req_len,
    output logic                           res_valid,
    input  logic                           res_ready,
    output brb_pkg::result_t               res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW:0] DEPTH_EXT = (CW + 1)'(DEPTH);
    localparam logic [brb_pkg::LEN_W-1:0] CHUNK_LEN = brb_pkg::LEN_W'(CHUNK_BYTES);

    brb_pkg::state_t state_reg, state_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [brb_pkg::LEN_W-1:0] n_reg, n_next;
    logic [brb_pkg::LANE_W-1:0] k_reg, k_next;
    logic status_reg, status_next;
    logic cap_reg, cap_next;
    logic [brb_pkg::LANE_W-1:0] cap_lane_reg, cap_lane_next;
    logic [brb_pkg::DATA_W-1:0] wdata_reg, wdata_next;
    logic [brb_pkg::DATA_W-1:0] acc_reg, acc_next;

    logic [brb_pkg::LEN_W-1:0] len_sat;
    logic [CW:0] write_sum;
    logic last;
    logic ram_we;
    logic [7:0] ram_q;

    brb_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wptr_reg),
        .wdata(wdata_reg[7:0]),
        .raddr(rptr_reg),
        .rdata(ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::ST_IDLE;
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        status_reg   <= status_next;
        cap_lane_reg <= cap_lane_next;
        wdata_reg    <= wdata_next;
        acc_reg      <= acc_next;
    end

    always_comb
    begin
        len_sat   = (req_len > CHUNK_LEN) ? CHUNK_LEN : req_len;
        write_sum = {1'b0, count_reg} + (CW + 1)'(len_sat);
        last      = ({1'b0, k_reg} == (n_reg - 4'd1));

        state_next    = state_reg;
        rptr_next     = rptr_reg;
        wptr_next     = wptr_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        status_next   = status_reg;
        cap_next      = 1'b0;
        cap_lane_next = cap_lane_reg;
        wdata_next    = wdata_reg;
        acc_next      = acc_reg;
        ram_we        = 1'b0;
        req_ready     = 1'b0;
        res_valid     = 1'b0;

        // place the byte fetched in the previous cycle into its lane
        if (cap_reg)
        begin
            acc_next[8*cap_lane_reg +: 8] = ram_q;
        end

        case (state_reg)
            brb_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    n_next      = '0;
                    k_next      = '0;
                    status_next = 1'b0;
                    wdata_next  = req_data;
                    acc_next    = '0;
                    state_next  = brb_pkg::ST_FINISH;
                    case (req_op)
                        brb_pkg::OP_WRITE:
                        begin
                            if (len_sat != '0)
                            begin
                                if (write_sum > DEPTH_EXT)
                                begin
                                    status_next = 1'b1;
                                end
                                else
                                begin
                                    n_next     = len_sat;
                                    count_next = write_sum[CW-1:0];
                                    state_next = brb_pkg::ST_WRITE;
                                end
                            end
                        end
                        brb_pkg::OP_READ:
                        begin
                            if ((CW + 1)'(len_sat) > {1'b0, count_reg})
                            begin
                                n_next = brb_pkg::LEN_W'(count_reg);
                            end
                            else
                            begin
                                n_next = len_sat;
                            end
                            count_next = count_reg - CW'(n_next);
                            if (n_next != '0)
                            begin
                                state_next = brb_pkg::ST_READ;
                            end
                        end
                        brb_pkg::OP_FLUSH:
                        begin
                            rptr_next  = '0;
                            wptr_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            brb_pkg::ST_WRITE:
            begin
                ram_we     = 1'b1;
                wdata_next = wdata_reg >> 8;
                wptr_next  = (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + 1'b1;
                k_next     = k_reg + 1'b1;
                if (last)
                begin
                    state_next = brb_pkg::ST_FINISH;
                end
            end
            brb_pkg::ST_READ:
            begin
                cap_next      = 1'b1;
                cap_lane_next = k_reg;
                rptr_next     = (rptr_reg == LAST_ADDR) ? '0 : rptr_reg + 1'b1;
                k_next        = k_reg + 1'b1;
                if (last)
                begin
                    state_next = brb_pkg::ST_READ_WAIT;
                end
            end
            brb_pkg::ST_READ_WAIT:
            begin
                state_next = brb_pkg::ST_FINISH;
            end
            brb_pkg::ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = brb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status     = status_reg;
        res.read_bytes = acc_reg;
        res.moved      = n_reg;
        res.fill_level = brb_pkg::FILL_W'(count_reg);
    end

endmodule

// File: design/byte_ring_buffer_chunked.sv
// Top level of the chunked circular byte FIFO: stream ports and result register.
//
// Each request is a write, read or flush of up to CHUNK_BYTES bytes against a ring
// store of DEPTH bytes. A write that would overflow is rejected whole, with status
// set and nothing stored. The store has a single byte-wide port per direction, so
// a request is worked one byte per cycle: a write stores its bytes and then gives its
// result; a read fetches its bytes, waits in a state for the store's registered read
// data and then gives its result; a flush, rejected write or zero-byte request gives
// its result straight away. One request is in work at a time; a new one is taken
// once the previous result sits in the output register, even before it is taken.
module byte_ring_buffer_chunked #(
    parameter int DEPTH       = 4096,
    parameter int CHUNK_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // write_bytes[63:0], length[67:64], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // read_bytes[63:0], moved[67:64], fill_level[80:68]
    output logic        m_tuser    // status[0]
);

    logic             res_valid;
    logic             res_ready;
    brb_pkg::result_t res;
    logic             out_valid_reg;
    brb_pkg::result_t out_reg;

    brb_seq #(
        .DEPTH      (DEPTH),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(s_tvalid),
        .req_ready(s_tready),
        .req_op   (s_tuser),
        .req_data (s_tdata[63:0]),
        .req_len  (s_tdata[67:64]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        // hold the result until taken
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'b0, out_reg.fill_level, out_reg.moved, out_reg.read_bytes};

endmodule

// File: design/brb_checker.sv
// Port-level checks of the chunked circular byte FIFO, bound to the top level.
module brb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser
);

    // a rejected write moves nothing and returns no bytes
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[67:0] == 68'd0)
        else $error("rejected write carries data");

    a_moved_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[67:64] <= 4'd8)
        else $error("moved count above chunk size");

    // only one request is in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind byte_ring_buffer_chunked brb_checker u_brb_checker (.*);
